// File: rtl/rqlh_pkg.sv
// Shared types, sizes and codes for the run-queue latency histogram.
// Used by rqlh_front, rqlh_back and run_queue_latency_histogram; no dependencies.
`default_nettype none

package rqlh_pkg;

	// Table sizes
	localparam int STAMP_ENTRIES = 1024;
	localparam int STAMP_AW      = ($clog2(STAMP_ENTRIES) > 0) ? $clog2(STAMP_ENTRIES) : 1;
	localparam int GROUP_ENTRIES = 64;
	localparam int GROUP_AW      = ($clog2(GROUP_ENTRIES) > 0) ? $clog2(GROUP_ENTRIES) : 1;
	localparam int HIST_SLOTS    = 26;
	localparam int COUNT_WIDTH   = 32;
	localparam int HIST_DEPTH    = GROUP_ENTRIES * HIST_SLOTS;
	localparam int HIST_AW       = ($clog2(HIST_DEPTH) > 0) ? $clog2(HIST_DEPTH) : 1;

	// Field widths
	localparam int ID_W     = 22;
	localparam int TIME_W   = 64;
	localparam int SLOT_W   = 5;
	localparam int OUT_CNT_W = 32;

	// Nanoseconds per microsecond; fits in 10 bits
	localparam int NS_PER_US = 1000;
	localparam int THR_W     = TIME_W + 10;

	// Event kinds
	localparam logic [1:0] KIND_WAKE   = 2'd0;
	localparam logic [1:0] KIND_SWITCH = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NO_STAMP  = 2'd1;
	localparam logic [1:0] ST_NEG_DELTA = 2'd2;
	localparam logic [1:0] ST_NO_GROUP  = 2'd3;

	// Input word
	typedef struct packed {
		logic [1:0]        kind;
		logic [TIME_W-1:0] time_ns;
		logic [ID_W-1:0]   first_pid;
		logic [ID_W-1:0]   first_group;
		logic              prev_running;
		logic [ID_W-1:0]   next_pid;
		logic [ID_W-1:0]   next_group;
		logic [SLOT_W-1:0] read_slot;
	} req_t;

	// Result word
	typedef struct packed {
		logic [1:0]           status;
		logic                 stamp_stored;
		logic [SLOT_W-1:0]    slot;
		logic [OUT_CNT_W-1:0] count;
	} rsp_t;

	// Classified command from the front to the back
	typedef struct packed {
		logic [1:0]        kind;
		logic [TIME_W-1:0] time_ns;
		logic [ID_W-1:0]   first_pid;
		logic              do_stamp;
		logic [ID_W-1:0]   next_pid;
		logic [ID_W-1:0]   next_group;
		logic [SLOT_W-1:0] read_slot;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} fe_out_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} bk_ctl_t;

	typedef enum logic [3:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SCAN,
		BK_STAMP_WR,
		BK_TIME_RD,
		BK_DELTA,
		BK_CHECK,
		BK_LOG,
		BK_GSCAN,
		BK_GRESOLVE,
		BK_ZERO,
		BK_CNT_RD,
		BK_CNT_WR,
		BK_DONE
	} bk_state_t;

	// Lowest delay in ns that lands in slot k or above
	function automatic logic [THR_W-1:0] slot_floor(input logic [SLOT_W-1:0] k);
		logic [THR_W-1:0] base;
		base = THR_W'(NS_PER_US);
		return base << k;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rqlh_front.sv
// Front end: group filter register, event classification and a two-entry command queue.
// Depends on rqlh_pkg.
`default_nettype none

module rqlh_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire rqlh_pkg::req_t               req,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [rqlh_pkg::ID_W-1:0]    cfg_data,
	output rqlh_pkg::fe_out_t                 fe_out,
	input  wire rqlh_pkg::bk_ctl_t            bk_ctl
);

	logic [rqlh_pkg::ID_W-1:0] filter_q;
	rqlh_pkg::cmd_t            cq_mem [2];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [1:0]                cnt_q;
	rqlh_pkg::cmd_t            cmd_in;
	logic                      accept;
	logic                      filt_ok;
	logic                      wants_stamp;

	assign cfg_ready = 1'b1;

	// Hold the group filter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= '0;
		end else if (cfg_valid) begin
			filter_q <= cfg_data;
		end
	end

	// Classify the incoming word
	always_comb begin
		filt_ok = (filter_q == '0) || (filter_q == req.first_group);
		wants_stamp = (req.kind == rqlh_pkg::KIND_WAKE) ||
			((req.kind == rqlh_pkg::KIND_SWITCH) && req.prev_running);
		cmd_in.kind       = req.kind;
		cmd_in.time_ns    = req.time_ns;
		cmd_in.first_pid  = req.first_pid;
		cmd_in.do_stamp   = wants_stamp && filt_ok && (req.first_pid != '0);
		cmd_in.next_pid   = req.next_pid;
		cmd_in.next_group = req.next_group;
		if (32'(req.read_slot) >= rqlh_pkg::HIST_SLOTS) begin
			cmd_in.read_slot = rqlh_pkg::SLOT_W'(rqlh_pkg::HIST_SLOTS - 1);
		end else begin
			cmd_in.read_slot = req.read_slot;
		end
	end

	assign full   = (cnt_q == 2'd2) || bk_ctl.clearing;
	assign accept = push && !full;

	// Advance the command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (bk_ctl.take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({accept, bk_ctl.take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store the classified word
	always_ff @(posedge clk) begin
		if (accept) begin
			cq_mem[wr_ptr_q] <= cmd_in;
		end
	end

	assign fe_out.valid = (cnt_q != 2'd0);
	assign fe_out.cmd   = cq_mem[rd_ptr_q];

endmodule

`default_nettype wire

// File: rtl/rqlh_back.sv
// Back end: stamp table, group table and histogram memories with their sequencer,
// plus a two-entry result queue. Depends on rqlh_pkg.
`default_nettype none

module rqlh_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rqlh_pkg::fe_out_t    fe_out,
	output rqlh_pkg::bk_ctl_t         bk_ctl,
	output logic                      empty,
	input  wire logic                 pop,
	output rqlh_pkg::rsp_t            rsp
);

	localparam int SAW = rqlh_pkg::STAMP_AW;
	localparam int GAW = rqlh_pkg::GROUP_AW;
	localparam int HAW = rqlh_pkg::HIST_AW;
	localparam int IW  = rqlh_pkg::ID_W;
	localparam int TW  = rqlh_pkg::TIME_W;
	localparam int SW  = rqlh_pkg::SLOT_W;
	localparam int CW  = rqlh_pkg::COUNT_WIDTH;

	rqlh_pkg::bk_state_t state_q, state_d;
	rqlh_pkg::cmd_t      cmd_q;

	// Memories
	logic [IW:0]   skey_mem  [rqlh_pkg::STAMP_ENTRIES];
	logic [TW-1:0] stime_mem [rqlh_pkg::STAMP_ENTRIES];
	logic [IW-1:0] gkey_mem  [rqlh_pkg::GROUP_ENTRIES];
	logic [CW-1:0] hist_mem  [rqlh_pkg::HIST_DEPTH];

	logic [IW:0]   skey_rd_q;
	logic [TW-1:0] stime_rd_q;
	logic [IW-1:0] gkey_rd_q;
	logic [CW-1:0] cnt_rd_q;

	logic          skey_we;
	logic [SAW-1:0] skey_wa, skey_ra;
	logic [IW:0]   skey_wd;
	logic          stime_we;
	logic [SAW-1:0] stime_wa, stime_ra;
	logic          gkey_we;
	logic [GAW-1:0] gkey_wa, gkey_ra;
	logic          hist_we;
	logic [HAW-1:0] hist_wa, hist_ra;
	logic [CW-1:0] hist_wd;

	// Stamp scan
	logic [SAW:0]   idx_q;
	logic           s_vld_s1;
	logic [SAW-1:0] s_idx_s1;
	logic           first_hit_q, next_hit_q, free_hit_q;
	logic [SAW-1:0] first_idx_q, next_idx_q, free_idx_q;
	logic [SAW-1:0] sel_idx_q;
	logic           stamp_ok;
	logic [SAW-1:0] stamp_idx;
	logic           next_found;

	// Delay to slot
	logic [TW-1:0] delta_q;
	logic [SW-1:0] k_q;

	// Group scan
	logic [GAW:0]   gidx_q;
	logic           g_vld_s1;
	logic [GAW-1:0] g_idx_s1;
	logic           ghit_q, gfree_q;
	logic [GAW-1:0] gmatch_idx_q, gfree_idx_q;
	logic [rqlh_pkg::GROUP_ENTRIES-1:0] gvalid_q;
	logic [HAW-1:0] hbase_q;
	logic [SW-1:0]  zidx_q;

	// Result fields
	logic [1:0]  status_q;
	logic        stored_q;
	logic [SW-1:0] slot_q;
	logic [rqlh_pkg::OUT_CNT_W-1:0] count_q;

	// Result queue
	rqlh_pkg::rsp_t ofifo_mem [2];
	logic           owr_q, ord_q;
	logic [1:0]     ocnt_q;
	logic           ofull;
	logic           opush, opop;
	logic           is_switch;

	assign is_switch  = (cmd_q.kind == rqlh_pkg::KIND_SWITCH);
	assign stamp_ok   = cmd_q.do_stamp && (first_hit_q || free_hit_q);
	assign stamp_idx  = first_hit_q ? first_idx_q : free_idx_q;
	assign next_found = next_hit_q || (stamp_ok && (cmd_q.next_pid == cmd_q.first_pid));

	assign ofull = (ocnt_q == 2'd2);
	assign bk_ctl.take     = (state_q == rqlh_pkg::BK_IDLE) && fe_out.valid && !ofull;
	assign bk_ctl.clearing = (state_q == rqlh_pkg::BK_CLEAR);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rqlh_pkg::BK_CLEAR: begin
				if (idx_q[SAW-1:0] == SAW'(rqlh_pkg::STAMP_ENTRIES - 1)) begin
					state_d = rqlh_pkg::BK_IDLE;
				end
			end
			rqlh_pkg::BK_IDLE: begin
				if (bk_ctl.take) begin
					case (fe_out.cmd.kind)
						rqlh_pkg::KIND_WAKE: state_d = fe_out.cmd.do_stamp ?
							rqlh_pkg::BK_SCAN : rqlh_pkg::BK_DONE;
						rqlh_pkg::KIND_SWITCH: state_d = rqlh_pkg::BK_SCAN;
						rqlh_pkg::KIND_READ:   state_d = rqlh_pkg::BK_GSCAN;
						default:               state_d = rqlh_pkg::BK_DONE;
					endcase
				end
			end
			rqlh_pkg::BK_SCAN: begin
				if ((idx_q == (SAW+1)'(rqlh_pkg::STAMP_ENTRIES)) && !s_vld_s1) begin
					state_d = rqlh_pkg::BK_STAMP_WR;
				end
			end
			rqlh_pkg::BK_STAMP_WR: begin
				if (is_switch && next_found) begin
					state_d = rqlh_pkg::BK_TIME_RD;
				end else begin
					state_d = rqlh_pkg::BK_DONE;
				end
			end
			rqlh_pkg::BK_TIME_RD: state_d = rqlh_pkg::BK_DELTA;
			rqlh_pkg::BK_DELTA:   state_d = rqlh_pkg::BK_CHECK;
			rqlh_pkg::BK_CHECK: begin
				state_d = delta_q[TW-1] ? rqlh_pkg::BK_DONE : rqlh_pkg::BK_LOG;
			end
			rqlh_pkg::BK_LOG: begin
				if (k_q >= SW'(rqlh_pkg::HIST_SLOTS - 1)) begin
					state_d = rqlh_pkg::BK_GSCAN;
				end
			end
			rqlh_pkg::BK_GSCAN: begin
				if ((gidx_q == (GAW+1)'(rqlh_pkg::GROUP_ENTRIES)) && !g_vld_s1) begin
					state_d = rqlh_pkg::BK_GRESOLVE;
				end
			end
			rqlh_pkg::BK_GRESOLVE: begin
				if (ghit_q) begin
					state_d = rqlh_pkg::BK_CNT_RD;
				end else if (is_switch && gfree_q) begin
					state_d = rqlh_pkg::BK_ZERO;
				end else begin
					state_d = rqlh_pkg::BK_DONE;
				end
			end
			rqlh_pkg::BK_ZERO: begin
				if (zidx_q == SW'(rqlh_pkg::HIST_SLOTS - 1)) begin
					state_d = rqlh_pkg::BK_CNT_RD;
				end
			end
			rqlh_pkg::BK_CNT_RD: state_d = rqlh_pkg::BK_CNT_WR;
			rqlh_pkg::BK_CNT_WR: state_d = rqlh_pkg::BK_DONE;
			rqlh_pkg::BK_DONE:   state_d = rqlh_pkg::BK_IDLE;
			default:             state_d = rqlh_pkg::BK_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		skey_we  = 1'b0;
		skey_wa  = '0;
		skey_wd  = '0;
		skey_ra  = idx_q[SAW-1:0];
		stime_we = 1'b0;
		stime_wa = stamp_idx;
		stime_ra = sel_idx_q;
		gkey_we  = 1'b0;
		gkey_wa  = gfree_idx_q;
		gkey_ra  = gidx_q[GAW-1:0];
		hist_we  = 1'b0;
		hist_wa  = hbase_q + HAW'(slot_q);
		hist_wd  = '0;
		hist_ra  = hbase_q + HAW'(slot_q);
		opush    = 1'b0;
		case (state_q)
			rqlh_pkg::BK_CLEAR: begin
				skey_we = 1'b1;
				skey_wa = idx_q[SAW-1:0];
			end
			rqlh_pkg::BK_STAMP_WR: begin
				if (stamp_ok) begin
					stime_we = 1'b1;
					if (!first_hit_q) begin
						skey_we = 1'b1;
						skey_wa = free_idx_q;
						skey_wd = {1'b1, cmd_q.first_pid};
					end
				end
			end
			rqlh_pkg::BK_DELTA: begin
				// drop the incoming task's stamp
				skey_we = 1'b1;
				skey_wa = sel_idx_q;
			end
			rqlh_pkg::BK_GRESOLVE: begin
				gkey_we = !ghit_q && is_switch && gfree_q;
			end
			rqlh_pkg::BK_ZERO: begin
				hist_we = 1'b1;
				hist_wa = hbase_q + HAW'(zidx_q);
			end
			rqlh_pkg::BK_CNT_WR: begin
				hist_we = is_switch;
				hist_wd = cnt_rd_q + CW'(1);
			end
			rqlh_pkg::BK_DONE: begin
				opush = 1'b1;
			end
			default: begin
				skey_we = 1'b0;
			end
		endcase
	end

	// Stamp key memory
	always_ff @(posedge clk) begin
		if (skey_we) begin
			skey_mem[skey_wa] <= skey_wd;
		end
		skey_rd_q <= skey_mem[skey_ra];
	end

	// Stamp time memory
	always_ff @(posedge clk) begin
		if (stime_we) begin
			stime_mem[stime_wa] <= cmd_q.time_ns;
		end
		stime_rd_q <= stime_mem[stime_ra];
	end

	// Group key memory
	always_ff @(posedge clk) begin
		if (gkey_we) begin
			gkey_mem[gkey_wa] <= cmd_q.next_group;
		end
		gkey_rd_q <= gkey_mem[gkey_ra];
	end

	// Histogram memory
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		cnt_rd_q <= hist_mem[hist_ra];
	end

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rqlh_pkg::BK_CLEAR;
			idx_q    <= '0;
			s_vld_s1 <= 1'b0;
			gidx_q   <= '0;
			g_vld_s1 <= 1'b0;
			gvalid_q <= '0;
		end else begin
			state_q  <= state_d;
			s_vld_s1 <= (state_q == rqlh_pkg::BK_SCAN) &&
				(idx_q < (SAW+1)'(rqlh_pkg::STAMP_ENTRIES));
			g_vld_s1 <= (state_q == rqlh_pkg::BK_GSCAN) &&
				(gidx_q < (GAW+1)'(rqlh_pkg::GROUP_ENTRIES));
			case (state_q)
				rqlh_pkg::BK_CLEAR: idx_q <= idx_q + (SAW+1)'(1);
				rqlh_pkg::BK_SCAN: begin
					if (idx_q < (SAW+1)'(rqlh_pkg::STAMP_ENTRIES)) begin
						idx_q <= idx_q + (SAW+1)'(1);
					end
				end
				default: idx_q <= '0;
			endcase
			if (state_q == rqlh_pkg::BK_GSCAN) begin
				if (gidx_q < (GAW+1)'(rqlh_pkg::GROUP_ENTRIES)) begin
					gidx_q <= gidx_q + (GAW+1)'(1);
				end
			end else begin
				gidx_q <= '0;
			end
			if (gkey_we) begin
				gvalid_q[gfree_idx_q] <= 1'b1;
			end
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		s_idx_s1 <= idx_q[SAW-1:0];
		g_idx_s1 <= gidx_q[GAW-1:0];
		case (state_q)
			rqlh_pkg::BK_IDLE: begin
				cmd_q       <= fe_out.cmd;
				first_hit_q <= 1'b0;
				next_hit_q  <= 1'b0;
				free_hit_q  <= 1'b0;
				status_q    <= rqlh_pkg::ST_DONE;
				stored_q    <= 1'b0;
				count_q     <= '0;
				slot_q      <= (fe_out.cmd.kind == rqlh_pkg::KIND_READ) ?
					fe_out.cmd.read_slot : '0;
			end
			rqlh_pkg::BK_SCAN: begin
				if (s_vld_s1) begin
					if (skey_rd_q[IW] && (skey_rd_q[IW-1:0] == cmd_q.first_pid) &&
						!first_hit_q) begin
						first_hit_q <= 1'b1;
						first_idx_q <= s_idx_s1;
					end
					if (skey_rd_q[IW] && (skey_rd_q[IW-1:0] == cmd_q.next_pid) &&
						!next_hit_q) begin
						next_hit_q <= 1'b1;
						next_idx_q <= s_idx_s1;
					end
					if (!skey_rd_q[IW] && !free_hit_q) begin
						free_hit_q <= 1'b1;
						free_idx_q <= s_idx_s1;
					end
				end
			end
			rqlh_pkg::BK_STAMP_WR: begin
				stored_q  <= stamp_ok;
				sel_idx_q <= (stamp_ok && (cmd_q.next_pid == cmd_q.first_pid)) ?
					stamp_idx : next_idx_q;
				if (is_switch && !next_found) begin
					status_q <= rqlh_pkg::ST_NO_STAMP;
				end
			end
			rqlh_pkg::BK_DELTA: begin
				delta_q <= cmd_q.time_ns - stime_rd_q;
			end
			rqlh_pkg::BK_CHECK: begin
				k_q <= SW'(1);
				if (delta_q[TW-1]) begin
					status_q <= rqlh_pkg::ST_NEG_DELTA;
				end
			end
			rqlh_pkg::BK_LOG: begin
				// thresholds rise with k, so the last one met is the slot
				if (rqlh_pkg::THR_W'(delta_q) >= rqlh_pkg::slot_floor(k_q)) begin
					slot_q <= k_q;
				end
				k_q     <= k_q + SW'(1);
				ghit_q  <= 1'b0;
				gfree_q <= 1'b0;
			end
			rqlh_pkg::BK_GSCAN: begin
				if (g_vld_s1) begin
					if (gvalid_q[g_idx_s1] && (gkey_rd_q == cmd_q.next_group) && !ghit_q) begin
						ghit_q       <= 1'b1;
						gmatch_idx_q <= g_idx_s1;
					end
					if (!gvalid_q[g_idx_s1] && !gfree_q) begin
						gfree_q     <= 1'b1;
						gfree_idx_q <= g_idx_s1;
					end
				end
			end
			rqlh_pkg::BK_GRESOLVE: begin
				zidx_q <= '0;
				if (ghit_q) begin
					hbase_q <= HAW'(gmatch_idx_q) * HAW'(rqlh_pkg::HIST_SLOTS);
				end else if (is_switch && gfree_q) begin
					hbase_q <= HAW'(gfree_idx_q) * HAW'(rqlh_pkg::HIST_SLOTS);
				end else begin
					status_q <= rqlh_pkg::ST_NO_GROUP;
					if (is_switch) begin
						slot_q <= '0;
					end
				end
			end
			rqlh_pkg::BK_ZERO: begin
				zidx_q <= zidx_q + SW'(1);
			end
			rqlh_pkg::BK_CNT_WR: begin
				if (is_switch) begin
					count_q <= rqlh_pkg::OUT_CNT_W'(CW'(cnt_rd_q + CW'(1)));
				end else begin
					count_q <= rqlh_pkg::OUT_CNT_W'(cnt_rd_q);
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
		// clear group scan flags before a read starts its scan
		if ((state_q == rqlh_pkg::BK_IDLE)) begin
			ghit_q  <= 1'b0;
			gfree_q <= 1'b0;
		end
	end

	// Result queue
	assign opop  = pop && !empty;
	assign empty = (ocnt_q == 2'd0);
	assign rsp   = ofifo_mem[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush) begin
				owr_q <= ~owr_q;
			end
			if (opop) begin
				ord_q <= ~ord_q;
			end
			case ({opush, opop})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (opush) begin
			ofifo_mem[owr_q] <= '{status: status_q, stamp_stored: stored_q,
				slot: slot_q, count: count_q};
		end
	end

endmodule

`default_nettype wire

// File: rtl/run_queue_latency_histogram.sv
// Run-queue latency histogram: wake stamps, per-group log2 latency histogram, count reads.
// Top level; instantiates rqlh_front and rqlh_back, depends on rqlh_pkg.
//
// Events enter through a queue-style port (push/full) and results leave through one
// (empty/pop), one result per event, in order. The front classifies each event and
// holds up to two; the back runs one at a time. The stamp table is searched by a
// linear sweep of its key memory, one entry a cycle, for a wake that stamps and for
// every switch. A switch whose incoming task has a stamp then adds a delay-to-slot
// step and, unless the delay is negative, a sweep of the group table, a row clear
// when a group is new, and a counter read-modify-write. A read sweeps only the group
// table and reads its counter. The back passes through a done state between events.
// After reset a clearing pass over all STAMP_ENTRIES (1024) stamp keys runs with full
// held high; the filter register may still be written then.
`default_nettype none

module run_queue_latency_histogram (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire rqlh_pkg::req_t            req,
	output logic                           empty,
	input  wire logic                      pop,
	output rqlh_pkg::rsp_t                 rsp,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [rqlh_pkg::ID_W-1:0] cfg_data
);

	rqlh_pkg::fe_out_t fe_out;
	rqlh_pkg::bk_ctl_t bk_ctl;

	// Classify and queue events
	rqlh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fe_out    (fe_out),
		.bk_ctl    (bk_ctl)
	);

	// Run table lookups and histogram updates
	rqlh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fe_out (fe_out),
		.bk_ctl (bk_ctl),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for run_queue_latency_histogram: directed and random scheduler events
// are checked against an in-bench model of the stamp table and group histograms.
// Depends on rqlh_pkg and the run_queue_latency_histogram RTL.
`timescale 1ns / 100ps

module tb_top;
	import rqlh_pkg::*;

	localparam int CYCLE_LIMIT = 8000000;
	localparam int RAND_ITEMS  = 1030;
	localparam int DRAIN_WAIT  = 1500;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	req_t req;
	logic empty;
	logic pop;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [ID_W-1:0] cfg_data;

	run_queue_latency_histogram dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Latency model state
	bit                   stamp_used [STAMP_ENTRIES];
	logic [ID_W-1:0]      stamp_pid  [STAMP_ENTRIES];
	logic [TIME_W-1:0]    stamp_at   [STAMP_ENTRIES];
	bit                   group_used [GROUP_ENTRIES];
	logic [ID_W-1:0]      group_id   [GROUP_ENTRIES];
	logic [COUNT_WIDTH-1:0] hist_count [HIST_DEPTH];
	logic [ID_W-1:0]      traced_group;

	rsp_t pending_rsp [$];
	int   mismatches;
	int   cycles;
	int   rx_hold_req;
	bit   no_idle;
	logic [TIME_W-1:0] now_ns;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("run_queue_latency_histogram: mismatch");
			$finish;
		end
	end

	function automatic int find_stamp(input logic [ID_W-1:0] pid);
		for (int i = 0; i < STAMP_ENTRIES; i++)
			if (stamp_used[i] && stamp_pid[i] == pid)
				return i;
		return -1;
	endfunction

	function automatic int find_group(input logic [ID_W-1:0] grp);
		for (int i = 0; i < GROUP_ENTRIES; i++)
			if (group_used[i] && group_id[i] == grp)
				return i;
		return -1;
	endfunction

	// Record a start stamp; returns 1 when written
	function automatic bit write_stamp(input logic [ID_W-1:0] pid, input logic [ID_W-1:0] grp,
			input logic [TIME_W-1:0] t);
		int i;
		if (pid == 0)
			return 0;
		if (traced_group != 0 && traced_group != grp)
			return 0;
		i = find_stamp(pid);
		if (i < 0) begin
			for (i = 0; i < STAMP_ENTRIES; i++)
				if (!stamp_used[i])
					break;
			if (i >= STAMP_ENTRIES)
				return 0;
			stamp_used[i] = 1;
			stamp_pid[i] = pid;
		end
		stamp_at[i] = t;
		return 1;
	endfunction

	// Work out the result word of one event and advance the model
	function automatic rsp_t predict_latency(input req_t r);
		rsp_t o;
		int s;
		int g;
		logic [TIME_W-1:0] delta;
		logic [TIME_W-1:0] us;
		int sl;
		o = '0;
		case (r.kind)
			KIND_WAKE: begin
				o.stamp_stored = write_stamp(r.first_pid, r.first_group, r.time_ns);
			end
			KIND_SWITCH: begin
				if (r.prev_running)
					o.stamp_stored = write_stamp(r.first_pid, r.first_group, r.time_ns);
				s = find_stamp(r.next_pid);
				if (s < 0) begin
					o.status = ST_NO_STAMP;
				end else begin
					delta = r.time_ns - stamp_at[s];
					if (delta[TIME_W-1]) begin
						o.status = ST_NEG_DELTA;
					end else begin
						g = find_group(r.next_group);
						if (g < 0) begin
							for (g = 0; g < GROUP_ENTRIES; g++)
								if (!group_used[g])
									break;
							if (g < GROUP_ENTRIES) begin
								group_used[g] = 1;
								group_id[g] = r.next_group;
								for (int k = 0; k < HIST_SLOTS; k++)
									hist_count[g * HIST_SLOTS + k] = '0;
							end else begin
								g = -1;
							end
						end
						if (g < 0) begin
							o.status = ST_NO_GROUP;
						end else begin
							us = delta / NS_PER_US;
							sl = 0;
							while (us > 1) begin
								us = us >> 1;
								sl++;
							end
							if (sl >= HIST_SLOTS)
								sl = HIST_SLOTS - 1;
							hist_count[g * HIST_SLOTS + sl] += 1'b1;
							o.slot = SLOT_W'(sl);
							o.count = hist_count[g * HIST_SLOTS + sl];
						end
					end
					stamp_used[s] = 0;
				end
			end
			KIND_READ: begin
				g = find_group(r.next_group);
				sl = (r.read_slot >= HIST_SLOTS) ? HIST_SLOTS - 1 : r.read_slot;
				o.slot = SLOT_W'(sl);
				if (g < 0)
					o.status = ST_NO_GROUP;
				else
					o.count = hist_count[g * HIST_SLOTS + sl];
			end
			default: ;
		endcase
		return o;
	endfunction

	// Offer one event word and record its expected result once accepted
	task automatic send_event(input req_t r);
		int gap;
		bit taken;
		gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		req <= r;
		taken = 0;
		// sample full away from the edge it is updated on
		while (!taken) begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end
		pending_rsp.push_back(predict_latency(r));
	endtask

	task automatic stop_push();
		push <= 1'b0;
		@(posedge clk);
	endtask

	// Hold until every expected result has come back
	task automatic drain();
		stop_push();
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_filter(input logic [ID_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		traced_group = v;
	endtask

	function automatic req_t make_event(input logic [1:0] k, input logic [TIME_W-1:0] t,
			input logic [ID_W-1:0] fp, input logic [ID_W-1:0] fg, input logic pr,
			input logic [ID_W-1:0] np, input logic [ID_W-1:0] ng, input logic [SLOT_W-1:0] rs);
		req_t r;
		r.kind = k; r.time_ns = t; r.first_pid = fp; r.first_group = fg;
		r.prev_running = pr; r.next_pid = np; r.next_group = ng; r.read_slot = rs;
		return r;
	endfunction

	// Receive side: random stall bursts, requested long holds, check each word
	initial begin
		int stall_left;
		int hold_left;
		rsp_t want;
		rsp_t got;
		bit took;
		stall_left = 0;
		hold_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			// sample the handshake away from the edge it is updated on
			@(negedge clk);
			took = pop && !empty;
			got = rsp;
			@(posedge clk);
			if (took) begin
				if (pending_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %p", got);
				end else begin
					want = pending_rsp.pop_front();
					if (got.status !== want.status || got.stamp_stored !== want.stamp_stored ||
							got.slot !== want.slot || got.count !== want.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (no_idle) begin
				pop <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Zero pid, restamp, slot 0, missing stamp, negative delta, reads, unused kind
	task automatic test_basic_events();
		send_event(make_event(KIND_WAKE, 64'd10, 22'd0, 22'd1, 1'b0, 22'd0, 22'd0, 5'd0));
		send_event(make_event(KIND_SWITCH, 64'd20, 22'd0, 22'd1, 1'b0, 22'd0, 22'd1, 5'd0));
		send_event(make_event(KIND_WAKE, 64'd1000, 22'd1, 22'd1, 1'b0, 22'd0, 22'd0, 5'd0));
		send_event(make_event(KIND_WAKE, 64'd2000, 22'd1, 22'd1, 1'b0, 22'd0, 22'd0, 5'd0));
		send_event(make_event(KIND_SWITCH, 64'd2999, 22'd2, 22'd1, 1'b1, 22'd1, 22'd1, 5'd0));
		send_event(make_event(KIND_SWITCH, 64'd3500, 22'd0, 22'd1, 1'b0, 22'd1, 22'd1, 5'd0));
		send_event(make_event(KIND_SWITCH, 64'd5, 22'd0, 22'd0, 1'b0, 22'd2, 22'd1, 5'd0));
		send_event(make_event(KIND_SWITCH, 64'd5, 22'd0, 22'd0, 1'b0, 22'd2, 22'd1, 5'd0));
		send_event(make_event(KIND_READ, 64'd0, 22'd0, 22'd0, 1'b0, 22'd0, 22'd1, 5'd0));
		send_event(make_event(KIND_READ, 64'd0, 22'd0, 22'd0, 1'b0, 22'd0, 22'd1, 5'd31));
		send_event(make_event(KIND_READ, 64'd0, 22'd0, 22'd0, 1'b0, 22'd0, 22'd77, 5'd3));
		send_event(make_event(2'd3, '1, '1, '1, 1'b1, '1, '1, '1));
		// Widest fields; a switch that stamps the pid it switches in sees a zero delay
		send_event(make_event(KIND_WAKE, 64'd0, '1, '1, 1'b0, 22'd0, 22'd0, 5'd0));
		send_event(make_event(KIND_SWITCH, 64'h7FFF_FFFF_FFFF_FFFF, '1, '1, 1'b1, '1, '1, 5'd0));
		send_event(make_event(KIND_SWITCH, '1, 22'd0, 22'd0, 1'b0, '1, '1, 5'd0));
		send_event(make_event(KIND_READ, 64'd0, 22'd0, 22'd0, 1'b0, 22'd0, '1, 5'd25));
		drain();
	endtask

	// Nonzero filter drops other groups; incoming task is not filtered
	task automatic test_group_filter();
		write_filter(22'd9);
		send_event(make_event(KIND_WAKE, 64'd100, 22'd3, 22'd8, 1'b0, 22'd0, 22'd0, 5'd0));
		send_event(make_event(KIND_SWITCH, 64'd200, 22'd3, 22'd8, 1'b0, 22'd3, 22'd8, 5'd0));
		send_event(make_event(KIND_WAKE, 64'd300, 22'd3, 22'd9, 1'b0, 22'd0, 22'd0, 5'd0));
		send_event(make_event(KIND_SWITCH, 64'd90000, 22'd4, 22'd8, 1'b1, 22'd3, 22'd8, 5'd0));
		send_event(make_event(KIND_SWITCH, 64'd90000, 22'd4, 22'd8, 1'b0, 22'd4, 22'd8, 5'd0));
		send_event(make_event(KIND_READ, 64'd0, 22'd0, 22'd0, 1'b0, 22'd0, 22'd8, 5'd6));
		drain();
		write_filter('1);
		send_event(make_event(KIND_WAKE, 64'd5, 22'd6, '1, 1'b0, 22'd0, 22'd0, 5'd0));
		send_event(make_event(KIND_WAKE, 64'd5, 22'd7, 22'd1, 1'b0, 22'd0, 22'd0, 5'd0));
		drain();
		write_filter(22'd0);
	endtask

	// Receiver holds off while the sender keeps offering, so full must rise
	task automatic test_backpressure();
		rx_hold_req = 6000;
		for (int i = 0; i < 8; i++)
			send_event(make_event(KIND_READ, 64'd0, 22'd0, 22'd0, 1'b0, 22'd0,
				22'($urandom_range(0, 3)), 5'($urandom_range(0, 31))));
		drain();
	endtask

	// One random event, mostly wakes and switches over a small pid and group pool
	task automatic random_event();
		req_t r;
		int p;
		int sh;
		logic [TIME_W-1:0] step;
		r = '0;
		p = $urandom_range(0, 99);
		step = {$urandom, $urandom};
		sh = $urandom_range(1, 40);
		now_ns = now_ns + (step >> (TIME_W - sh));
		r.time_ns = now_ns;
		r.first_pid = 22'($urandom_range(1, 40));
		r.first_group = 22'(r.first_pid % 12 + 1);
		r.next_pid = 22'($urandom_range(1, 40));
		r.next_group = 22'(r.next_pid % 12 + 1);
		r.prev_running = $urandom_range(0, 1);
		r.read_slot = 5'($urandom_range(0, 31));
		if (p < 35) begin
			r.kind = KIND_WAKE;
		end else if (p < 75) begin
			r.kind = KIND_SWITCH;
			if ($urandom_range(0, 19) == 0)
				r.time_ns = now_ns - {$urandom, $urandom} % 64'd1000000;
		end else if (p < 92) begin
			r.kind = KIND_READ;
			r.next_group = 22'($urandom_range(0, 14));
		end else begin
			r.kind = 2'($urandom_range(0, 3));
			r.time_ns = {$urandom, $urandom};
			r.first_pid = 22'($urandom);
			r.first_group = 22'($urandom);
			r.next_pid = 22'($urandom);
			r.next_group = 22'($urandom);
			r.read_slot = 5'($urandom);
		end
		send_event(r);
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS / 3) begin
				drain();
				write_filter(22'd5);
			end else if (i == RAND_ITEMS / 2) begin
				drain();
				write_filter(22'd0);
			end else if (i == RAND_ITEMS - 60) begin
				no_idle = 1;
			end
			random_event();
		end
		drain();
	endtask

	// Fill the group table; groups beyond its capacity find no row
	task automatic test_group_table_full();
		for (int g = 0; g <= GROUP_ENTRIES; g++) begin
			send_event(make_event(KIND_WAKE, 64'd1000, 22'd500, 22'(200 + g), 1'b0,
				22'd0, 22'd0, 5'd0));
			send_event(make_event(KIND_SWITCH, 64'd9000, 22'd0, 22'd0, 1'b0,
				22'd500, 22'(200 + g), 5'd0));
		end
		send_event(make_event(KIND_READ, 64'd0, 22'd0, 22'd0, 1'b0, 22'd0, 22'd200, 5'd2));
		send_event(make_event(KIND_READ, 64'd0, 22'd0, 22'd0, 1'b0, 22'd0,
			22'(200 + GROUP_ENTRIES), 5'd2));
		drain();
	endtask

	initial begin
		push = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		cycles = 0;
		rx_hold_req = 0;
		no_idle = 0;
		now_ns = 64'd1000;
		traced_group = '0;
		for (int i = 0; i < STAMP_ENTRIES; i++) stamp_used[i] = 0;
		for (int i = 0; i < GROUP_ENTRIES; i++) group_used[i] = 0;
		for (int i = 0; i < HIST_DEPTH; i++) hist_count[i] = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_filter(22'd0);
		test_basic_events();
		test_group_filter();
		test_backpressure();
		test_random_traffic();
		test_group_table_full();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("run_queue_latency_histogram: match");
		end else begin
			$display("run_queue_latency_histogram: mismatch");
		end
		$finish;
	end

endmodule
